// ----- src/rmsd_pkg.sv -----
// shared constants and types for the running mean and standard deviation block
package rmsd_pkg;

  localparam int SampleW       = 24;
  localparam int SumW          = 40;
  localparam int SqSumW        = 64;
  localparam int CntW          = 17;
  localparam int StdW          = 23;
  localparam int ProdW         = 2 * SampleW;
  localparam int RootW         = SqSumW / 2;
  localparam int MaxSamplesDef = 65536;

  localparam logic [StdW-1:0] StdMax = {StdW{1'b1}};

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } iter_op_e;

  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_cmd_t;

endpackage

// ----- src/rmsd_iter.sv -----
// shared shift-subtract unit: restoring divide and digit-by-digit square root
module rmsd_iter import rmsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iter_cmd_t         cmd_i,
  input  logic [SqSumW-1:0] operand_i,
  input  logic [CntW-1:0]   divisor_i,
  output logic              done_o,
  output logic [SqSumW-1:0] result_o
);

  localparam int DivSteps  = SqSumW;
  localparam int SqrtSteps = RootW;
  localparam int StepW     = $clog2(DivSteps);
  localparam int RemW      = RootW + 3;

  logic              busy_q;
  logic              done_q;
  iter_op_e          op_q;
  logic [StepW-1:0]  cnt_q;
  logic [SqSumW-1:0] sh_q;
  logic [RemW-1:0]   rem_q;
  logic [RootW-1:0]  root_q;
  logic [CntW-1:0]   dvs_q;

  logic [RemW-1:0]   trial;
  logic [RemW-1:0]   sub_b;
  logic [RemW:0]     diff;
  logic              ge;
  logic              last_step;
  logic [RemW-1:0]   rem_d;

  always_comb begin
    case (op_q)
      OP_DIV: begin
        trial     = {{(RemW-CntW-1){1'b0}}, rem_q[CntW-1:0], sh_q[SqSumW-1]};
        sub_b     = {{(RemW-CntW){1'b0}}, dvs_q};
        last_step = (cnt_q == StepW'(DivSteps - 1));
      end
      OP_SQRT: begin
        trial     = {rem_q[RemW-3:0], sh_q[SqSumW-1:SqSumW-2]};
        sub_b     = {1'b0, root_q, 2'b01};
        last_step = (cnt_q == StepW'(SqrtSteps - 1));
      end
      default: begin
        trial     = '0;
        sub_b     = '0;
        last_step = 1'b1;
      end
    endcase
    diff  = {1'b0, trial} - {1'b0, sub_b};
    ge    = ~diff[RemW];
    rem_d = ge ? diff[RemW-1:0] : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      cnt_q  <= '0;
      sh_q   <= '0;
      rem_q  <= '0;
      root_q <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (busy_q) begin
        rem_q <= rem_d;
        cnt_q <= cnt_q + StepW'(1);
        if (op_q == OP_DIV) begin
          sh_q <= {sh_q[SqSumW-2:0], ge};
        end else begin
          sh_q   <= {sh_q[SqSumW-3:0], 2'b00};
          root_q <= {root_q[RootW-2:0], ge};
        end
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end else if (cmd_i.start) begin
        busy_q <= 1'b1;
        op_q   <= cmd_i.op;
        cnt_q  <= '0;
        sh_q   <= operand_i;
        rem_q  <= '0;
        root_q <= '0;
        dvs_q  <= divisor_i;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = (op_q == OP_DIV) ? sh_q : {{(SqSumW-RootW){1'b0}}, root_q};

endmodule

// ----- src/running_mean_stddev_top.sv -----
// Running mean and population standard deviation of signed Q12.12 samples.
// Samples are taken one per cycle while the block collects a set; each is squared in a
// two-stage pipeline and added into a 40-bit sum and a 64-bit sum of squares. The word
// carrying last_sample ends the set: the input stalls (longer while the previous result
// word has not been taken) while one shared shift-subtract unit computes sum / count
// (64 steps), sum of squares / count (64 steps) and the square root of the variance
// (32 steps), then the result word is loaded into the output register and the next set
// may start while that word still waits to be taken. Samples past MaxSamples are not
// counted and raise truncated.
module running_mean_stddev_top import rmsd_pkg::*; #(
  parameter int MaxSamples = MaxSamplesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      last_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] mean_o,
  output logic        [StdW-1:0]    std_dev_o,
  output logic        [CntW-1:0]    sample_total_o,
  output logic                      truncated_o
);

  typedef enum logic [3:0] {
    ST_ACC,
    ST_DRAIN,
    ST_DIVM_GO,
    ST_DIVM_WAIT,
    ST_MUL,
    ST_DIVS_GO,
    ST_DIVS_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_FIN
  } state_e;

  state_e state_q;

  // accumulation pipeline
  logic                      p0_valid_q;
  logic signed [SampleW-1:0] p0_s_q;
  logic                      p1_valid_q;
  logic signed [SampleW-1:0] p1_s_q;
  logic        [ProdW-1:0]   prod_q;
  logic signed [SumW-1:0]    sum_q;
  logic        [SqSumW-1:0]  sq_q;
  logic        [CntW-1:0]    cnt_q;
  logic                      drop_q;

  // final computation
  logic signed [SampleW-1:0] mean_q;
  logic        [SqSumW-1:0]  var_q;
  logic        [StdW-1:0]    std_q;

  // output register
  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_mean_q;
  logic        [StdW-1:0]    out_std_q;
  logic        [CntW-1:0]    out_total_q;
  logic                      out_trunc_q;

  logic                      in_acc;
  logic                      has_room;
  logic signed [SampleW-1:0] mul_a;
  logic signed [ProdW-1:0]   mul_p;
  logic        [SumW-1:0]    sum_abs;
  logic        [SampleW:0]   mean_mag;
  logic        [SampleW:0]   mean_signed;
  logic        [SqSumW-1:0]  msq;
  logic        [RootW-1:0]   root_w;

  iter_cmd_t                 iter_cmd;
  logic        [SqSumW-1:0]  iter_opnd;
  logic                      iter_done;
  logic        [SqSumW-1:0]  iter_res;

  assign in_stall_o = (state_q != ST_ACC);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign has_room   = (cnt_q < CntW'(MaxSamples));

  // the multiplier squares pipeline samples, and the mean once per set
  assign mul_a = (state_q == ST_MUL) ? mean_q : p0_s_q;
  assign mul_p = mul_a * mul_a;

  assign sum_abs     = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign mean_mag    = iter_res[SampleW:0];
  assign mean_signed = sum_q[SumW-1] ? (SampleW+1)'(-mean_mag) : mean_mag;
  assign msq         = {{(SqSumW-ProdW){1'b0}}, prod_q};
  assign root_w      = iter_res[RootW-1:0];

  always_comb begin
    iter_cmd.start = 1'b0;
    iter_cmd.op    = OP_DIV;
    iter_opnd      = '0;
    case (state_q)
      ST_DIVM_GO: begin
        iter_cmd.start = 1'b1;
        iter_opnd      = {{(SqSumW-SumW){1'b0}}, sum_abs};
      end
      ST_DIVS_GO: begin
        iter_cmd.start = 1'b1;
        iter_opnd      = sq_q;
      end
      ST_SQRT_GO: begin
        iter_cmd.start = 1'b1;
        iter_cmd.op    = OP_SQRT;
        iter_opnd      = var_q;
      end
      default: begin
        iter_cmd.start = 1'b0;
      end
    endcase
  end

  rmsd_iter u_iter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (iter_cmd),
    .operand_i (iter_opnd),
    .divisor_i (cnt_q),
    .done_o    (iter_done),
    .result_o  (iter_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      p0_valid_q  <= 1'b0;
      p0_s_q      <= '0;
      p1_valid_q  <= 1'b0;
      p1_s_q      <= '0;
      prod_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      mean_q      <= '0;
      var_q       <= '0;
      std_q       <= '0;
      out_valid_q <= 1'b0;
      out_mean_q  <= '0;
      out_std_q   <= '0;
      out_total_q <= '0;
      out_trunc_q <= 1'b0;
    end else begin
      // in ST_FIN the load below decides out_valid_q
      if (out_valid_q && !out_stall_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end

      // sample intake
      p0_valid_q <= in_acc && has_room;
      if (in_acc) begin
        if (has_room) begin
          p0_s_q     <= sample_i;
          cnt_q      <= cnt_q + CntW'(1);
        end else begin
          drop_q <= 1'b1;
        end
      end

      // square stage
      p1_valid_q <= p0_valid_q;
      if (p0_valid_q || state_q == ST_MUL) begin
        prod_q <= ProdW'(mul_p);
        p1_s_q <= p0_s_q;
      end

      // accumulate stage
      if (p1_valid_q) begin
        sum_q <= sum_q + SumW'(p1_s_q);
        sq_q  <= sq_q + msq;
      end

      case (state_q)
        ST_ACC: begin
          if (in_acc && last_sample_i) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!p0_valid_q && !p1_valid_q) begin
            state_q <= ST_DIVM_GO;
          end
        end
        ST_DIVM_GO: begin
          state_q <= ST_DIVM_WAIT;
        end
        ST_DIVM_WAIT: begin
          if (iter_done) begin
            mean_q  <= mean_signed[SampleW-1:0];
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_DIVS_GO;
        end
        ST_DIVS_GO: begin
          state_q <= ST_DIVS_WAIT;
        end
        ST_DIVS_WAIT: begin
          if (iter_done) begin
            // variance in Q24, non-positive gives zero
            var_q   <= (iter_res > msq) ? (iter_res - msq) : '0;
            state_q <= ST_SQRT_GO;
          end
        end
        ST_SQRT_GO: begin
          state_q <= ST_SQRT_WAIT;
        end
        ST_SQRT_WAIT: begin
          if (iter_done) begin
            std_q   <= (root_w > RootW'(StdMax)) ? StdMax : root_w[StdW-1:0];
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_mean_q  <= mean_q;
            out_std_q   <= std_q;
            out_total_q <= cnt_q;
            out_trunc_q <= drop_q;
            sum_q       <= '0;
            sq_q        <= '0;
            cnt_q       <= '0;
            drop_q      <= 1'b0;
            state_q     <= ST_ACC;
          end
        end
        default: begin
          state_q <= ST_ACC;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mean_o         = out_mean_q;
  assign std_dev_o      = out_std_q;
  assign sample_total_o = out_total_q;
  assign truncated_o    = out_trunc_q;

endmodule

// ----- verif/tb_running_mean_stddev_top.sv -----
// testbench for running_mean_stddev_top: directed and random sample sets against a local predictor
`timescale 1ns / 1ps

module tb_running_mean_stddev_top;
  import rmsd_pkg::*;

  localparam int MaxSamplesTb = MaxSamplesDef;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles = 300;
  localparam int RandomItems = 300;
  localparam int IdlePct = 21;
  localparam int HoldCycles = 500;
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};

  typedef struct {
    logic signed [SampleW-1:0] mean;
    logic [StdW-1:0]           std_dev;
    logic [CntW-1:0]           total;
    logic                      truncated;
  } set_stats_t;

  class stats_scoreboard;
    longint     value_sum;
    bit [63:0]  square_sum;
    int         accepted;
    bit         dropped;
    int         max_samples;
    set_stats_t stats_q[$];
    int         mismatches;
    int         failures;

    function new(int limit);
      max_samples = limit;
      mismatches = 0;
      failures = 0;
      clear_set();
    endfunction

    function void clear_set();
      value_sum = 0;
      square_sum = 0;
      accepted = 0;
      dropped = 0;
    endfunction

    function bit [63:0] floor_root(bit [63:0] x);
      bit [63:0] r;
      bit [63:0] c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= x) r = c;
      end
      return r;
    endfunction

    function int pending();
      return stats_q.size();
    endfunction

    // fold one accepted word into the running set, queue stats when it closes the set
    function void note_sample(logic signed [SampleW-1:0] s, logic is_last);
      longint     v;
      longint     m;
      bit [63:0]  msq;
      bit [63:0]  avg_sq;
      bit [63:0]  root;
      set_stats_t r;
      v = longint'(s);
      if (accepted < max_samples) begin
        value_sum += v;
        square_sum += 64'(v * v);
        accepted++;
      end else begin
        dropped = 1;
      end
      if (!is_last) return;
      m = 0;
      root = 0;
      if (accepted != 0) begin
        m = value_sum / longint'(accepted);
        msq = 64'(m * m);
        avg_sq = square_sum / 64'(accepted);
        if (avg_sq > msq) root = floor_root(avg_sq - msq);
        if (root > 64'(StdMax)) root = 64'(StdMax);
      end
      r.mean = m[SampleW-1:0];
      r.std_dev = root[StdW-1:0];
      r.total = accepted[CntW-1:0];
      r.truncated = dropped;
      stats_q.push_back(r);
      clear_set();
    endfunction

    function void check_result(set_stats_t got);
      set_stats_t want;
      if (stats_q.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: mean %0d std %0d total %0d trunc %0b",
                   got.mean, got.std_dev, got.total, got.truncated);
        return;
      end
      want = stats_q.pop_front();
      if (got.mean !== want.mean || got.std_dev !== want.std_dev ||
          got.total !== want.total || got.truncated !== want.truncated) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: mean %0d/%0d std %0d/%0d total %0d/%0d trunc %0b/%0b (exp/got)",
                   want.mean, got.mean, want.std_dev, got.std_dev,
                   want.total, got.total, want.truncated, got.truncated);
      end
    endfunction

    function void close_out();
      if (stats_q.size() != 0) begin
        failures += stats_q.size();
        $display("%0d expected result words never arrived", stats_q.size());
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_i = '0;
  logic                      last_sample_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [SampleW-1:0] mean_o;
  logic        [StdW-1:0]    std_dev_o;
  logic        [CntW-1:0]    sample_total_o;
  logic                      truncated_o;

  stats_scoreboard sb;
  int in_idle_pct = IdlePct;
  int out_idle_pct = IdlePct;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  running_mean_stddev_top #(
    .MaxSamples(MaxSamplesTb)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sample_i,
    .last_sample_i,
    .out_valid_o,
    .out_stall_i,
    .mean_o,
    .std_dev_o,
    .sample_total_o,
    .truncated_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // drive one word and hold it until the block takes it
  task automatic send_word(input logic signed [SampleW-1:0] s, input logic is_last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    last_sample_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(s, is_last);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(5))
      0: return SampleMin;
      1: return SampleMax;
      2: return SampleW'($urandom_range(8192)) - SampleW'(4096);
      default: return SampleW'($urandom());
    endcase
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send_word(pick_sample(), i == len - 1);
  endtask

  // result side: take words, stall at random or for a requested hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result('{mean_o, std_dev_o, sample_total_o, truncated_o});
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int items;
    int len;
    sb = new(MaxSamplesTb);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-word sets at zero and both extremes
    send_word('0, 1'b1);
    send_word(SampleMin, 1'b1);
    send_word(SampleMax, 1'b1);
    // widest spread, root lands exactly on StdMax without being clamped
    send_word(SampleMin, 1'b0);
    send_word(SampleMax, 1'b1);
    // negative mean truncates toward zero
    send_word(-24'sd3, 1'b0);
    send_word(-24'sd4, 1'b1);
    send_word(24'sd1, 1'b0);
    send_word(24'sd2, 1'b0);
    send_word(24'sd3, 1'b0);
    send_word(24'sd4, 1'b1);
    // constant set gives zero variance
    send_word(24'sd5, 1'b0);
    send_word(24'sd5, 1'b0);
    send_word(24'sd5, 1'b1);
    send_word(-24'sd1, 1'b0);
    send_word(-24'sd2, 1'b1);
    send_word(24'h555555, 1'b0);
    send_word(24'haaaaaa, 1'b1);
    wait_all_results();

    // receiver holds off while sets keep coming, so the block backs up
    hold_req = HoldCycles;
    for (int k = 0; k < 4; k++) send_set(3);
    wait_all_results();

    // long stretch with no idling on either side
    in_idle_pct = 0;
    out_idle_pct = 0;
    for (int k = 0; k < 3; k++) send_set(32);
    wait_all_results();

    items = 0;
    while (items < RandomItems) begin
      if ($urandom_range(9) == 0) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = IdlePct;
        out_idle_pct = IdlePct;
      end
      len = ($urandom_range(3) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      send_set(len);
      items += len;
    end
    wait_all_results();
    repeat (DrainCycles) @(posedge clk_i);

    sb.close_out();
    if (sb.failures == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
